>>> hdl/fqgh_pkg.sv
// ----------------------------------------------------------------------------
// fqgh_pkg
// Shared widths and types for the first quadratic gcd hit search block.
// ----------------------------------------------------------------------------
`default_nettype none

package fqgh_pkg;

	// Width of the modulus that the search works on
	localparam int MODULUS_BITS = 32;
	// Fixed widths of the stream fields
	localparam int IN_BITS      = 32;
	localparam int HIT_BITS     = 16;
	// Floor square root of the modulus fits in this many bits
	localparam int ROOT_BITS    = (MODULUS_BITS + 1) / 2;
	// Datapath width: holds 2t^2-1 for any t up to the root, and the modulus
	localparam int VAL_BITS     = 2 * ROOT_BITS + 1;

	typedef logic [MODULUS_BITS-1:0] mod_t;
	typedef logic [ROOT_BITS-1:0]    root_t;
	typedef logic [VAL_BITS-1:0]     val_t;

	// Status that the gcd unit hands back to the sequencer
	typedef struct packed {
		logic done;
		val_t g;
	} gcd_rsp_t;

endpackage

`default_nettype wire

>>> hdl/fqgh_isqrt.sv
// ----------------------------------------------------------------------------
// fqgh_isqrt
// Bit-by-bit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fqgh_isqrt
	import fqgh_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire mod_t  n,
	output logic       done,
	output root_t      root
);

	val_t rem_q;
	val_t res_q;
	val_t bit_q;
	logic busy_q;

	val_t trial;
	logic take;

	// Trial subtraction for the current bit pair
	assign trial = res_q + bit_q;
	assign take  = (rem_q >= trial);
	assign root  = ROOT_BITS'(res_q);

	// Run the recurrence from the top bit pair down to bit zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	// Datapath: remainder, partial root and the moving bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= VAL_BITS'(n);
			res_q <= '0;
			bit_q <= VAL_BITS'(1) << (2 * ROOT_BITS - 2);
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

`default_nettype wire

>>> hdl/fqgh_gcd.sv
// ----------------------------------------------------------------------------
// fqgh_gcd
// Shared binary gcd unit: one halve or one subtract per cycle.
// The second operand must be odd; the first must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module fqgh_gcd
	import fqgh_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire val_t a_in,
	input  wire val_t b_in,
	output gcd_rsp_t  rsp
);

	typedef enum logic {
		G_IDLE,
		G_RUN
	} gstate_t;

	gstate_t state_q;
	val_t    a_q;
	val_t    b_q;
	logic    done_q;

	assign rsp.done = done_q;
	assign rsp.g    = a_q;

	// Control: run until both operands meet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						state_q <= G_RUN;
					end
				end
				G_RUN: begin
					if (a_q == b_q) begin
						state_q <= G_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	// Datapath: the odd operand keeps the gcd unchanged under halving of the other
	always_ff @(posedge clk) begin
		if (start && state_q == G_IDLE) begin
			a_q <= a_in;
			b_q <= b_in;
		end else if (state_q == G_RUN) begin
			if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_q - b_q;
			end else if (b_q > a_q) begin
				b_q <= b_q - a_q;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/first_quadratic_gcd_hit_search_top.sv
// ----------------------------------------------------------------------------
// first_quadratic_gcd_hit_search_top
// Finds the smallest t below floor(sqrt(N)) with 1 < gcd(N, 2t^2-1) < N.
// ----------------------------------------------------------------------------
// Usage:
//   One modulus N enters as a beat on the s_ channel; one beat with the
//   hit position (0 when no t qualifies) leaves on the m_ channel.
//   s_tready is high only while the sequencer is idle; one modulus is in
//   work at a time. s_tready rises together with m_tvalid.
// Search steps:
//   An empty scan runs the square root and setup, one check and the
//   hand-off. Each candidate t tried adds its sequencing through ST_CHECK
//   and ST_GCD plus one binary gcd step per cycle in the shared gcd unit,
//   so the search is longest when no t qualifies.
// Output:
//   The result sits in an output register. While the receiver stalls, the
//   register holds and a next modulus may already be taken and searched;
//   its result waits in the sequencer until the register frees.
// Reset:
//   arst_n clears the sequencer and the output valid; the block comes up
//   ready with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module first_quadratic_gcd_hit_search_top
	import fqgh_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [IN_BITS-1:0]  s_tdata,   // [31:0] modulus
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [HIT_BITS-1:0]      m_tdata    // [15:0] hit_position
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_CHECK,
		ST_GCD,
		ST_DONE
	} state_t;

	state_t   state_q;
	mod_t     n_q;
	root_t    s_q;
	root_t    t_q;
	val_t     v_q;
	root_t    hit_q;
	logic     root_go_q;
	logic     gcd_go_q;

	logic     root_done;
	root_t    root_val;
	gcd_rsp_t gcd_rsp;
	logic     in_beat;
	logic     hit;
	logic     out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	// Nontrivial shared factor
	assign hit      = (gcd_rsp.g > VAL_BITS'(1)) && (gcd_rsp.g < VAL_BITS'(n_q));

	fqgh_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_go_q),
		.n      (n_q),
		.done   (root_done),
		.root   (root_val)
	);

	fqgh_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_go_q),
		.a_in   (VAL_BITS'(n_q)),
		.b_in   (v_q),
		.rsp    (gcd_rsp)
	);

	// Sequencer: root, then one gcd per candidate, then hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			root_go_q <= 1'b0;
			gcd_go_q  <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			root_go_q <= 1'b0;
			gcd_go_q  <= 1'b0;
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						root_go_q <= 1'b1;
						state_q   <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (t_q < s_q) begin
						gcd_go_q <= 1'b1;
						state_q  <= ST_GCD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_GCD: begin
					if (gcd_rsp.done) begin
						state_q <= hit ? ST_DONE : ST_CHECK;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload: modulus, root, candidate and its value 2t^2-1
	always_ff @(posedge clk) begin
		if (in_beat) begin
			n_q   <= MODULUS_BITS'(s_tdata);
			t_q   <= ROOT_BITS'(1);
			v_q   <= VAL_BITS'(1);
			hit_q <= '0;
		end
		if (state_q == ST_ROOT && root_done) begin
			s_q <= root_val;
		end
		if (state_q == ST_GCD && gcd_rsp.done) begin
			if (hit) begin
				hit_q <= t_q;
			end else begin
				// Advance: 2(t+1)^2-1 = v + 4t + 2
				t_q <= t_q + ROOT_BITS'(1);
				v_q <= v_q + (VAL_BITS'(t_q) << 2) + VAL_BITS'(2);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata <= HIT_BITS'(hit_q);
		end
	end

endmodule

`default_nettype wire

>>> hdl/fqgh_checker.sv
// ----------------------------------------------------------------------------
// fqgh_checker
// Port-level checks on the hit search block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fqgh_checker
	import fqgh_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [IN_BITS-1:0]  s_tdata,   // [31:0] modulus
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [HIT_BITS-1:0] m_tdata    // [15:0] hit_position
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Drop ready once a modulus is taken
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("block ready right after taking a modulus");

	// No result appears the cycle after a modulus is taken
	a_no_instant_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// Returning to ready always comes with a fresh result on the output
	a_ready_with_out: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $rose(s_tready) |-> m_tvalid)
		else $error("ready again without a result beat");

	// Input data is only observed at beats
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown(s_tdata))
		else $error("unknown modulus accepted");

endmodule

bind first_quadratic_gcd_hit_search_top fqgh_checker u_fqgh_checker (.*);

`default_nettype wire

>>> tb/first_quadratic_gcd_hit_search_top_tb.sv
// ----------------------------------------------------------------------------
// first_quadratic_gcd_hit_search_top_tb
// Self-checking bench for the quadratic gcd hit search block.
// Moduli go in as s_ beats and a scoreboard predicts each hit position.
// Every m_ beat is compared with the oldest prediction. Both sides idle at
// random. The random moduli are chosen so that most searches end early.
// ----------------------------------------------------------------------------
`default_nettype none

module first_quadratic_gcd_hit_search_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fqgh_pkg::*;

	typedef logic [HIT_BITS-1:0] hit_t;

	// One pending search: the modulus that went in and the hit it must give
	typedef struct {
		mod_t modulus;
		hit_t hit;
	} hit_entry_t;

	// Predict hit positions in order and compare the returned beats
	class hit_scoreboard;
		hit_entry_t pending_hits[$];
		int         fault_count = 0;

		// Smallest t below floor(sqrt(n)) with 1 < gcd(n, 2t^2-1) < n, else 0
		function hit_t predict_hit_position(mod_t n);
			longint unsigned num, root, trial, cand, a, b, r;
			num = n;
			if (num < 4) begin
				return '0;
			end
			// Build the floor root one bit at a time, high bit first
			root = 0;
			for (int k = ROOT_BITS - 1; k >= 0; k--) begin
				trial = root | (64'd1 << k);
				if (trial * trial <= num) begin
					root = trial;
				end
			end
			for (cand = 1; cand < root; cand++) begin
				a = num;
				b = 2 * cand * cand - 1;
				while (b != 0) begin
					r = a % b;
					a = b;
					b = r;
				end
				if (a > 1 && a < num) begin
					return cand[HIT_BITS-1:0];
				end
			end
			return '0;
		endfunction

		function void note_modulus(mod_t n);
			hit_entry_t e;
			e.modulus = n;
			e.hit     = predict_hit_position(n);
			pending_hits.push_back(e);
		endfunction

		task report_mismatch(string what, mod_t n, hit_t got, hit_t want);
			$display("MISMATCH %s: modulus=%0d got=%0d want=%0d", what, n, got, want);
			fault_count++;
		endtask

		task check_hit(hit_t got);
			hit_entry_t e;
			if (pending_hits.size() == 0) begin
				report_mismatch("beat with no pending modulus", '0, got, '0);
			end else begin
				e = pending_hits.pop_front();
				if (got !== e.hit) begin
					report_mismatch("hit_position", e.modulus, got, e.hit);
				end
			end
		endtask

		function int pending_count();
			return pending_hits.size();
		endfunction
	endclass

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_BITS-1:0] s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [HIT_BITS-1:0] m_tdata;

	hit_scoreboard board = new;
	bit            no_idle = 1'b0;
	int            ready_hold = 0;

	first_quadratic_gcd_hit_search_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(99);
		if (no_idle) begin
			return 0;
		end
		if (sel < 65) begin
			return 0;
		end else if (sel < 94) begin
			return $urandom_range(4, 1);
		end else begin
			return $urandom_range(200, 20);
		end
	endfunction

	// Small moduli, multiples of primes that divide some 2t^2-1, and mid-size
	function automatic mod_t pick_modulus();
		int unsigned     factors[8] = '{7, 17, 23, 31, 41, 47, 71, 73};
		int unsigned     f;
		longint unsigned prod;
		int              sel;
		sel = $urandom_range(99);
		if (sel < 5) begin
			return mod_t'($urandom_range(15, 0));
		end else if (sel < 60) begin
			return mod_t'($urandom_range(4095, 16));
		end else if (sel < 85) begin
			f    = factors[$urandom_range(7, 0)];
			prod = longint'(f) * $urandom_range(32'hFFFF_FFFF / f, 2);
			return mod_t'(prod);
		end else begin
			return mod_t'($urandom_range((1 << 18) - 1, 0));
		end
	endfunction

	// Drive one modulus beat after an optional gap and wait for the handshake
	task automatic send_modulus(mod_t n);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_BITS'(n);
		do begin
			@(posedge clk);
		end while (!s_tready);
		board.note_modulus(n);
	endtask

	// Hold the sender until every pending hit has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.pending_count() != 0) begin
			@(posedge clk);
		end
	endtask

	// Take result beats and stall the receiver at random
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			board.check_hit(m_tdata);
		end
		if (ready_hold > 0) begin
			m_tready <= 1'b0;
			ready_hold = ready_hold - 1;
		end else begin
			m_tready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	// Main sequence: reset, directed moduli, random moduli, drain, verdict
	initial begin
		mod_t directed[$] = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd8,
			32'd9, 32'd14, 32'd15, 32'd17, 32'd31, 32'd49, 32'd97,
			32'd119, 32'd1023, 32'd4096, 32'hFFFF_FFFF, 32'hFFFF_FFF9,
			32'hAAAA_AAAB, 32'h8000_0007
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: zero, below four, gcd equal to N, no divisor, wide values
		foreach (directed[i]) begin
			send_modulus(directed[i]);
		end
		wait_drained();

		for (int i = 0; i < 78; i++) begin
			no_idle = (i >= 40 && i < 60);
			if (i % 25 == 24) begin
				wait_drained();
			end
			send_modulus(pick_modulus());
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;

		// Drain, then give the block time to show any stray beat
		while (board.pending_count() != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);

		if (board.fault_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Stop a run that hangs
	initial begin
		#300_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
